>>> rtl/rit_pkg.sv
// Shared constants and the digit-to-character function for radix_integer_to_text.
package rit_pkg;

  // Parameter default and fixed field widths
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned VALUE_IN_W      = 32;
  localparam int unsigned BASE_IN_W       = 8;
  localparam int unsigned CHAR_W          = 7;
  // Radix 2..36 fits in six bits once range-checked
  localparam int unsigned RADIX_W         = 6;

  localparam logic [BASE_IN_W-1:0] BASE_MIN  = 8'd2;
  localparam logic [BASE_IN_W-1:0] BASE_MAX  = 8'd36;
  localparam logic [BASE_IN_W-1:0] SIGN_BASE = 8'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  // 0-9 then a-z
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A + dx - CHAR_W'(DEC_DIGITS);
    end
  endfunction

endpackage

>>> rtl/radix_integer_to_text.sv
// Top level: integer to text in radix 2..36, one character per strobe.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  command  | start (in), busy (out)    | command_i, value_i, base_i
//  result   | strobe_o (out)            | character_o, last_o
//
// A transaction is taken when start is high and busy is low. The serial
// divider produces one digit per division, least significant first; an
// invalid base skips straight to the NUL terminator. Digits are parked in
// a small RAM, then read out in reverse, each character through a read
// state and a show state. Reset returns the sequencer to idle; nothing
// else needs clearing. The receiver cannot stall the result strobe.
module radix_integer_to_text import rit_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command_i,
  input  logic [VALUE_IN_W-1:0] value_i,
  input  logic [BASE_IN_W-1:0]  base_i,
  output logic                  strobe_o,
  output logic [CHAR_W-1:0]     character_o,
  output logic                  last_o
);

  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_READ,
    S_SHOW,
    S_NUL
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    nd_q;
  logic                neg_q;
  logic [RADIX_W-1:0]  base_q;
  logic                strobe_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;

  logic                   accept;
  logic                   base_ok;
  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;
  logic                   quo_zero;

  logic                   ram_we;
  logic [CNT_W-1:0]       nd_dec;
  logic [CHAR_W-1:0]      ram_rdata;

  // Transaction decode and sign handling
  assign accept  = start && !busy;
  assign base_ok = (base_i >= BASE_MIN) && (base_i <= BASE_MAX);
  assign v_in    = VALUE_WIDTH'(value_i);
  assign neg_in  = command_i && (base_i == SIGN_BASE) && v_in[VALUE_WIDTH-1];
  assign mag_in  = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;

  // Divider launch: first digit from the input, later ones from the quotient
  assign quo_zero     = (div_quo == '0);
  assign div_start    = (accept && base_ok) || ((state_q == S_DIV) && div_done && !quo_zero);
  assign div_dividend = (state_q == S_IDLE) ? mag_in : div_quo;
  assign div_divisor  = (state_q == S_IDLE) ? base_i[RADIX_W-1:0] : base_q;

  rit_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // Digit buffer, least significant digit at address zero
  assign ram_we = (state_q == S_DIV) && div_done;
  assign nd_dec = nd_q - CNT_W'(1);

  rit_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nd_q[ADDR_W-1:0]),
    .wdata_i(digit_char(div_rem)),
    .raddr_i(nd_dec[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Sequencer with registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nd_q     <= '0;
      neg_q    <= 1'b0;
      base_q   <= '0;
      strobe_q <= 1'b0;
      char_q   <= CHAR_NUL;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            nd_q   <= '0;
            neg_q  <= neg_in;
            base_q <= base_i[RADIX_W-1:0];
            state_q <= base_ok ? S_DIV : S_NUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nd_q <= nd_q + CNT_W'(1);
            if (quo_zero) begin
              state_q <= neg_q ? S_SIGN : S_READ;
            end
          end
        end
        S_SIGN: begin
          strobe_q <= 1'b1;
          char_q   <= CHAR_MINUS;
          state_q  <= S_READ;
        end
        S_READ: begin
          nd_q    <= nd_dec;
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          strobe_q <= 1'b1;
          char_q   <= ram_rdata;
          state_q  <= (nd_q == '0) ? S_NUL : S_READ;
        end
        S_NUL: begin
          strobe_q <= 1'b1;
          char_q   <= CHAR_NUL;
          last_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Checks
  a_last_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> (character_o == CHAR_NUL))
    else $error("last flag on a non-NUL character");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

  a_digit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (nd_q < CNT_W'(VALUE_WIDTH)))
    else $error("digit buffer overrun");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

endmodule

>>> rtl/rit_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rit_divider.sv
// Bit-serial restoring divider: value by a small radix, one quotient bit per cycle.
module rit_divider import rit_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_W-1:0]     divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [RADIX_W-1:0]     remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_q;
  logic [RADIX_W-1:0]     rem_q;
  logic [RADIX_W-1:0]     div_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   run_q;
  logic                   done_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  logic [RADIX_W:0] rem_sh;
  logic [RADIX_W:0] rem_diff;
  logic             fits;

  assign rem_sh   = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign fits     = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(VALUE_WIDTH);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits as it shifts
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> tb/radix_integer_to_text_test.sv
// Self-checking bench for radix_integer_to_text: random and corner conversions against a predictor.
module radix_integer_to_text_test;
  import rit_pkg::*;

  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam int unsigned N_RANDOM    = 305;
  localparam int unsigned QUIET_LIMIT = 8000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned PRINT_MAX   = 50;
  // Random items in this window are sent back to back
  localparam int unsigned BURST_FROM  = 120;
  localparam int unsigned BURST_TO    = 200;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Predicts the text of each accepted command and checks the characters as they arrive
  class text_checker;
    text_char_t  text_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_MAX) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    function void note_command(logic cmd, logic [VALUE_IN_W-1:0] value,
                               logic [BASE_IN_W-1:0] base);
      logic [VW-1:0]     mag;
      logic [VW-1:0]     radix;
      logic [VW-1:0]     d;
      logic              neg;
      logic [CHAR_W-1:0] digits[$];
      mag   = value[VW-1:0];
      radix = VW'(base);
      neg   = 1'b0;
      // Out-of-range radix: terminator only
      if (base < BASE_MIN || base > BASE_MAX) begin
        text_q.push_back('{ch: CHAR_NUL, last: 1'b1});
        return;
      end
      // Sign only for signed decimal; most negative value negates to itself
      if (cmd && base == SIGN_BASE && mag[VW-1]) begin
        neg = 1'b1;
        mag = ~mag + VW'(1);
      end
      do begin
        d = mag % radix;
        if (d < 10) digits.push_front(CHAR_ZERO + CHAR_W'(d));
        else digits.push_front(CHAR_A + CHAR_W'(d - 10));
        mag = mag / radix;
      end while (mag != 0);
      if (neg) text_q.push_back('{ch: CHAR_MINUS, last: 1'b0});
      foreach (digits[i]) text_q.push_back('{ch: digits[i], last: 1'b0});
      text_q.push_back('{ch: CHAR_NUL, last: 1'b1});
    endfunction

    task check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      if (text_q.size() == 0) begin
        report($sformatf("character 0x%02h last=%0b with nothing outstanding", ch, last));
        return;
      end
      want = text_q.pop_front();
      if (ch !== want.ch) begin
        report($sformatf("character 0x%02h, predicted 0x%02h", ch, want.ch));
      end
      if (last !== want.last) begin
        report($sformatf("last %0b, predicted %0b (character 0x%02h)", last, want.last, ch));
      end
    endtask
  endclass

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  start     = 1'b0;
  logic                  command_i = 1'b0;
  logic [VALUE_IN_W-1:0] value_i   = '0;
  logic [BASE_IN_W-1:0]  base_i    = '0;
  logic                  busy;
  logic                  strobe_o;
  logic [CHAR_W-1:0]     character_o;
  logic                  last_o;

  text_checker board = new();
  int unsigned quiet_cycles = 0;
  logic        no_gaps      = 1'b0;

  radix_integer_to_text dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .value_i    (value_i),
    .base_i     (base_i),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  // 2-unit clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Capture accepted commands and emitted characters
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) board.note_command(command_i, value_i, base_i);
    if (rst_ni && strobe_o) board.check_char(character_o, last_o);
  end

  // Watchdog on cycles with no transaction either side
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one command and hold it until taken; idle cycles carry junk fields
  task send_command(logic cmd, logic [VALUE_IN_W-1:0] val, logic [BASE_IN_W-1:0] base);
    while (!no_gaps && $urandom_range(99) < 15) begin
      start     <= 1'b0;
      command_i <= 1'($urandom_range(1));
      value_i   <= $urandom;
      base_i    <= BASE_IN_W'($urandom_range(255));
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 300 : 6)) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    base_i    <= base;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  function automatic logic [VALUE_IN_W-1:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom_range(0, 40);
      1: return $urandom;
      2: case ($urandom_range(2))
           0: return 32'h7fff_ffff - $urandom_range(0, 3);
           1: return 32'h8000_0000 + $urandom_range(0, 3);
           default: return 32'hffff_ffff - $urandom_range(0, 3);
         endcase
      3: return -$urandom_range(1, 1000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [BASE_IN_W-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return ($urandom_range(1) == 0) ? BASE_IN_W'($urandom_range(0, 1))
                                      : BASE_IN_W'($urandom_range(37, 255));
    end
    else if (r < 35) return SIGN_BASE;
    else return BASE_IN_W'($urandom_range(BASE_MIN, BASE_MAX));
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero, field extremes, signs, radix limits
    send_command(1'b0, 32'd0,         SIGN_BASE);
    send_command(1'b1, 32'd0,         SIGN_BASE);
    send_command(1'b0, 32'hffff_ffff, BASE_MIN);
    send_command(1'b0, 32'hffff_ffff, BASE_MAX);
    send_command(1'b0, 32'hffff_ffff, 8'd16);
    send_command(1'b0, 32'hffff_ffff, SIGN_BASE);
    send_command(1'b1, 32'hffff_ffff, SIGN_BASE);
    send_command(1'b1, 32'h8000_0000, SIGN_BASE);
    send_command(1'b0, 32'h8000_0000, SIGN_BASE);
    send_command(1'b1, 32'h7fff_ffff, SIGN_BASE);
    send_command(1'b1, 32'h8000_0000, 8'd16);
    send_command(1'b1, 32'hffff_fff6, BASE_MIN);
    send_command(1'b0, 32'd35,        BASE_MAX);
    send_command(1'b0, 32'd9,         SIGN_BASE);
    send_command(1'b0, 32'd1,         BASE_MIN);
    send_command(1'b0, 32'd4095,      8'd8);
    send_command(1'b1, 32'd1234,      8'd0);
    send_command(1'b0, 32'd1234,      8'd1);
    send_command(1'b0, 32'd1234,      8'd37);
    send_command(1'b1, 32'hffff_ffff, 8'd255);
    send_command(1'b0, 32'h5555_5555, 8'd3);
    send_command(1'b1, 32'haaaa_aaaa, 8'd35);

    // Random conversions, with a burst of back-to-back commands
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      no_gaps = (i >= BURST_FROM && i < BURST_TO);
      send_command(1'($urandom_range(1)), pick_value(), pick_base());
    end
    start <= 1'b0;

    while (board.text_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rit_pkg.sv
rtl/rit_ram.sv
rtl/rit_divider.sv
rtl/radix_integer_to_text.sv
tb/radix_integer_to_text_test.sv
